FILE: hdl/nakdr_pkg.sv
// ----------------------------------------------------------------------------
// nakdr_pkg
// Shared types, codes and sizes of the NAK dedup repair engine.
// ----------------------------------------------------------------------------
package nakdr_pkg;

   localparam int CACHE_ENTRIES = 16;
   localparam int MAX_REPAIRS   = 64;
   localparam int CMDQ_DEPTH    = 2;

   localparam int IDX_W  = $clog2(CACHE_ENTRIES);
   localparam int CNT_W  = $clog2(MAX_REPAIRS + 1);
   localparam int QPTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int QCNT_W = $clog2(CMDQ_DEPTH + 1);

   // result kinds
   localparam logic [1:0] KIND_REPAIR    = 2'd0;
   localparam logic [1:0] KIND_DUPLICATE = 2'd1;
   localparam logic [1:0] KIND_WRONG_SRC = 2'd2;
   localparam logic [1:0] KIND_NONE      = 2'd3;

   // request opcodes
   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_REFRESH = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_OWN_ADDRESS   = 2'd0;
   localparam logic [1:0] CSR_GROUP_ADDRESS = 2'd1;
   localparam logic [1:0] CSR_REPAIR_SIZE   = 2'd2;

   localparam logic [15:0] REPAIR_SIZE_RESET = 16'd1000;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MATCH,
      F_COMMIT
   } front_state_type;

   typedef enum logic {
      B_IDLE,
      B_EMIT
   } back_state_type;

   // one command from the front to the back: a run of count results
   typedef struct packed {
      logic [1:0]       kind;
      logic [30:0]      seq_lo;
      logic [CNT_W-1:0] count;
      logic             truncated;
      logic [31:0]      dest_address;
      logic [15:0]      dest_port;
      logic [7:0]       dest_iface;
      logic [15:0]      packet_size;
      logic [15:0]      entry_dups;
      logic [15:0]      max_dups;
   } cmd_type;

endpackage

FILE: hdl/nakdr_front.sv
// ----------------------------------------------------------------------------
// nakdr_front
// Accepts requests, matches them against the request cache, updates the
// cache and pushes one command per request.
// ----------------------------------------------------------------------------
module nakdr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [31:0]        req_request_source,
   input  logic [30:0]        req_range_low,
   input  logic [30:0]        req_range_high,
   input  logic [31:0]        req_turn_address,
   input  logic [15:0]        req_turn_port,
   input  logic [7:0]         req_turn_iface,
   input  logic [31:0]        own_address,
   input  logic [15:0]        repair_size,
   output logic               cmd_push,
   output nakdr_pkg::cmd_type cmd_data,
   input  logic               cmd_full
);
   import nakdr_pkg::*;

   front_state_type state_ff, state_in;

   // held request
   logic        op_ff;
   logic [31:0] src_ff;
   logic [30:0] lo_ff;
   logic [30:0] hi_ff;
   logic [31:0] taddr_ff;
   logic [15:0] tport_ff;
   logic [7:0]  tif_ff;

   // match results
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0] victim_ff, victim_in;
   logic             wrong_ff, wrong_in;
   logic             empty_ff, empty_in;
   logic             trunc_ff, trunc_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // request cache
   logic [CACHE_ENTRIES-1:0] valid_ff;
   logic [30:0]              low_ff   [CACHE_ENTRIES];
   logic [30:0]              high_ff  [CACHE_ENTRIES];
   logic [31:0]              addr_ff  [CACHE_ENTRIES];
   logic [7:0]               iface_ff [CACHE_ENTRIES];
   logic [15:0]              dup_ff   [CACHE_ENTRIES];
   logic [IDX_W-1:0]         age_ff   [CACHE_ENTRIES];
   logic [15:0]              max_dup_ff;

   logic             free_found;
   logic [IDX_W-1:0] free_idx;
   logic [IDX_W-1:0] old_idx;
   logic [31:0]      len;
   logic [15:0]      cur_dup;
   logic [15:0]      dup_new;
   logic [15:0]      max_new;
   logic             is_req;
   logic             is_dup;
   logic             is_new;

   // parallel match, first free slot, oldest entry, run length
   always_comb begin
      hit_in     = 1'b0;
      hit_idx_in = '0;
      free_found = 1'b0;
      free_idx   = '0;
      old_idx    = '0;
      for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && low_ff[i] == lo_ff && high_ff[i] == hi_ff &&
             addr_ff[i] == taddr_ff && iface_ff[i] == tif_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
         if (age_ff[i] == IDX_W'(CACHE_ENTRIES - 1)) begin
            old_idx = IDX_W'(i);
         end
      end
      victim_in = free_found ? free_idx : old_idx;
      wrong_in  = (src_ff != own_address);
      empty_in  = (hi_ff < lo_ff);
      len       = {1'b0, hi_ff} - {1'b0, lo_ff} + 32'd1;
      trunc_in  = !empty_in && (len > 32'(MAX_REPAIRS));
      count_in  = trunc_in ? CNT_W'(MAX_REPAIRS) : len[CNT_W-1:0];
   end

   // duplicate bookkeeping and command build
   always_comb begin
      cur_dup = dup_ff[hit_idx_ff];
      dup_new = (cur_dup == 16'hFFFF) ? cur_dup : cur_dup + 16'd1;
      max_new = (dup_new > max_dup_ff) ? dup_new : max_dup_ff;
      is_req  = (op_ff == OP_REQUEST);
      is_dup  = is_req && !wrong_ff && hit_ff;
      is_new  = is_req && !wrong_ff && !hit_ff;

      cmd_data              = '0;
      cmd_data.kind         = KIND_NONE;
      cmd_data.count        = CNT_W'(1);
      cmd_data.dest_address = taddr_ff;
      cmd_data.dest_port    = tport_ff;
      cmd_data.dest_iface   = tif_ff;
      cmd_data.packet_size  = repair_size;
      cmd_data.max_dups     = max_dup_ff;
      if (!is_req) begin
         cmd_data.dest_address = '0;
         cmd_data.dest_port    = '0;
         cmd_data.dest_iface   = '0;
         cmd_data.packet_size  = '0;
      end else if (wrong_ff) begin
         cmd_data.kind = KIND_WRONG_SRC;
      end else if (hit_ff) begin
         cmd_data.kind       = KIND_DUPLICATE;
         cmd_data.entry_dups = dup_new;
         cmd_data.max_dups   = max_new;
      end else if (!empty_ff) begin
         cmd_data.kind      = KIND_REPAIR;
         cmd_data.seq_lo    = lo_ff;
         cmd_data.count     = count_ff;
         cmd_data.truncated = trunc_ff;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd_push  = 1'b0;
      case (state_ff)
         F_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = F_MATCH;
            end
         end
         F_MATCH: begin
            state_in = F_COMMIT;
         end
         F_COMMIT: begin
            if (!cmd_full) begin
               cmd_push = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && req_valid) begin
         op_ff    <= req_op;
         src_ff   <= req_request_source;
         lo_ff    <= req_range_low;
         hi_ff    <= req_range_high;
         taddr_ff <= req_turn_address;
         tport_ff <= req_turn_port;
         tif_ff   <= req_turn_iface;
      end
      if (state_ff == F_MATCH) begin
         hit_ff     <= hit_in;
         hit_idx_ff <= hit_idx_in;
         victim_ff  <= victim_in;
         wrong_ff   <= wrong_in;
         empty_ff   <= empty_in;
         trunc_ff   <= trunc_in;
         count_ff   <= count_in;
      end
   end

   // cache control state: valid bits, ages, running maximum
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         max_dup_ff <= '0;
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else if (cmd_push && is_dup) begin
         max_dup_ff <= max_new;
      end else if (cmd_push && is_new) begin
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (IDX_W'(i) == victim_ff) begin
               age_ff[i] <= '0;
            end else if (valid_ff[i]) begin
               age_ff[i] <= age_ff[i] + IDX_W'(1);
            end
         end
         valid_ff[victim_ff] <= 1'b1;
      end
   end

   // cache payload
   always_ff @(posedge clock) begin
      if (cmd_push && is_dup) begin
         dup_ff[hit_idx_ff] <= dup_new;
      end else if (cmd_push && is_new) begin
         low_ff[victim_ff]   <= lo_ff;
         high_ff[victim_ff]  <= hi_ff;
         addr_ff[victim_ff]  <= taddr_ff;
         iface_ff[victim_ff] <= tif_ff;
         dup_ff[victim_ff]   <= '0;
      end
   end

endmodule

FILE: hdl/nakdr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// nakdr_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module nakdr_cmd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  nakdr_pkg::cmd_type push_data,
   output logic               full,
   input  logic               pop,
   output nakdr_pkg::cmd_type pop_data,
   output logic               empty
);
   import nakdr_pkg::*;

   cmd_type           mem_ff [CMDQ_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (fill_ff == QCNT_W'(CMDQ_DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/nakdr_back.sv
// ----------------------------------------------------------------------------
// nakdr_back
// Expands each command into its run of result words, one per cycle while
// the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module nakdr_back (
   input  logic               clock,
   input  logic               reset,
   input  nakdr_pkg::cmd_type cmd_data,
   input  logic               cmd_empty,
   output logic               cmd_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [30:0]        rsp_repair_seqno,
   output logic [31:0]        rsp_dest_address,
   output logic [15:0]        rsp_dest_port,
   output logic [7:0]         rsp_dest_iface,
   output logic [15:0]        rsp_packet_size,
   output logic [15:0]        rsp_entry_dups,
   output logic [15:0]        rsp_max_dups,
   output logic               rsp_truncated,
   output logic               rsp_last
);
   import nakdr_pkg::*;

   back_state_type   state_ff, state_in;
   cmd_type          cmd_ff;
   logic [CNT_W-1:0] off_ff, off_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;
   logic             last_now;
   logic             emit;

   logic [1:0]  kind_ff;
   logic [30:0] seqno_ff;
   logic [31:0] daddr_ff;
   logic [15:0] dport_ff;
   logic [7:0]  diface_ff;
   logic [15:0] size_ff;
   logic [15:0] edups_ff;
   logic [15:0] mdups_ff;
   logic        trunc_ff;
   logic        last_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last_now = ((off_ff + CNT_W'(1)) == cmd_ff.count);

   always_comb begin
      state_in = state_ff;
      cmd_pop  = 1'b0;
      emit     = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (out_free) begin
               emit = 1'b1;
               if (last_now) begin
                  if (!cmd_empty) begin
                     cmd_pop = 1'b1;
                  end else begin
                     state_in = B_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      off_in = off_ff;
      if (cmd_pop) begin
         off_in = '0;
      end else if (emit) begin
         off_in = off_ff + CNT_W'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff <= off_in;
      if (cmd_pop) begin
         cmd_ff <= cmd_data;
      end
      if (emit) begin
         kind_ff   <= cmd_ff.kind;
         seqno_ff  <= cmd_ff.seq_lo + 31'(off_ff);
         daddr_ff  <= cmd_ff.dest_address;
         dport_ff  <= cmd_ff.dest_port;
         diface_ff <= cmd_ff.dest_iface;
         size_ff   <= cmd_ff.packet_size;
         edups_ff  <= cmd_ff.entry_dups;
         mdups_ff  <= cmd_ff.max_dups;
         trunc_ff  <= cmd_ff.truncated;
         last_ff   <= last_now;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_repair_seqno = seqno_ff;
   assign rsp_dest_address = daddr_ff;
   assign rsp_dest_port    = dport_ff;
   assign rsp_dest_iface   = diface_ff;
   assign rsp_packet_size  = size_ff;
   assign rsp_entry_dups   = edups_ff;
   assign rsp_max_dups     = mdups_ff;
   assign rsp_truncated    = trunc_ff;
   assign rsp_last         = last_ff;

endmodule

FILE: hdl/nak_dedup_repair_engine_core.sv
// ----------------------------------------------------------------------------
// nak_dedup_repair_engine_core
// Repair engine of a reliable-multicast sender with duplicate request
// suppression: request cache in the front, repair run generator in the back.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake            | moves
//   ---------+-----------+----------------------+------------------------------
//   req_     | in        | req_valid/req_stall  | one repair request or refresh
//   rsp_     | out       | rsp_valid/rsp_stall  | one result word per cycle unless stalled
//   csr_     | in        | csr_write_en         | register write, no read-back
//
// The front takes a request through its accept, parallel cache match and
// commit states; commit updates the cache and pushes one command once the
// command queue has room. The back turns a command into 1 to MAX_REPAIRS
// result words, one a cycle while the output is not stalled.
// Reset is synchronous; cache valid bits clear at once, no clearing pass.
// A stalled result holds in the output register; the two-entry command
// queue lets the front keep accepting while the back waits.
//
module nak_dedup_repair_engine_core (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data,
   // requests
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_request_source,
   input  logic [30:0] req_range_low,
   input  logic [30:0] req_range_high,
   input  logic [31:0] req_turn_address,
   input  logic [15:0] req_turn_port,
   input  logic [7:0]  req_turn_iface,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [30:0] rsp_repair_seqno,
   output logic [31:0] rsp_dest_address,
   output logic [15:0] rsp_dest_port,
   output logic [7:0]  rsp_dest_iface,
   output logic [15:0] rsp_packet_size,
   output logic [15:0] rsp_entry_dups,
   output logic [15:0] rsp_max_dups,
   output logic        rsp_truncated,
   output logic        rsp_last
);
   import nakdr_pkg::*;

   logic [31:0] own_address_ff, own_address_in;
   logic [15:0] repair_size_ff, repair_size_in;

   cmd_type cmd_push_data;
   cmd_type cmd_pop_data;
   logic    cmd_push;
   logic    cmd_full;
   logic    cmd_pop;
   logic    cmd_empty;

   // register writes; the group address only goes on the wire as packet
   // header and shows on no result field, so drop it here
   always_comb begin
      own_address_in = own_address_ff;
      repair_size_in = repair_size_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_OWN_ADDRESS: begin
               own_address_in = csr_write_data;
            end
            CSR_REPAIR_SIZE: begin
               repair_size_in = csr_write_data[15:0];
            end
            default: begin
               own_address_in = own_address_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= '0;
         repair_size_ff <= REPAIR_SIZE_RESET;
      end else begin
         own_address_ff <= own_address_in;
         repair_size_ff <= repair_size_in;
      end
   end

   // classify and update the cache
   nakdr_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_request_source (req_request_source),
      .req_range_low      (req_range_low),
      .req_range_high     (req_range_high),
      .req_turn_address   (req_turn_address),
      .req_turn_port      (req_turn_port),
      .req_turn_iface     (req_turn_iface),
      .own_address        (own_address_ff),
      .repair_size        (repair_size_ff),
      .cmd_push           (cmd_push),
      .cmd_data           (cmd_push_data),
      .cmd_full           (cmd_full)
   );

   // decouple front and back
   nakdr_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_pop_data),
      .empty     (cmd_empty)
   );

   // expand commands into result words
   nakdr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_data         (cmd_pop_data),
      .cmd_empty        (cmd_empty),
      .cmd_pop          (cmd_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_repair_seqno (rsp_repair_seqno),
      .rsp_dest_address (rsp_dest_address),
      .rsp_dest_port    (rsp_dest_port),
      .rsp_dest_iface   (rsp_dest_iface),
      .rsp_packet_size  (rsp_packet_size),
      .rsp_entry_dups   (rsp_entry_dups),
      .rsp_max_dups     (rsp_max_dups),
      .rsp_truncated    (rsp_truncated),
      .rsp_last         (rsp_last)
   );

endmodule
